// ===== rtl/core/hrap_pkg.sv =====
// ============================================================================
// hrap_pkg
// Shared widths, constants and types for the HRAP grid projection pipeline.
// ============================================================================
package hrap_pkg;

    // Angle in degrees, Q16, after the longitude shift
    localparam int DEG_W  = 27;
    // CORDIC datapath width (Q30 plus headroom)
    localparam int CW     = 34;
    // Sine / cosine result width (Q30, signed)
    localparam int TRIG_W = 32;

    // Divider geometry
    localparam int MAG_W  = 60;  // |radius * p| magnitude
    localparam int DEN_W  = 32;  // 2^30 + sin(lat), positive
    localparam int DIV_QW = 25;  // quotient bits kept before overflow
    localparam int DIV_NW = 53;  // rounded, pre-scaled numerator
    localparam int DIV_RW = 57;  // partial remainder

    localparam int FULL_TURN = 23592960;  // 360 deg, Q16
    localparam int HALF_TURN = 11796480;  // 180 deg, Q16
    localparam int QUARTER   = 5898240;   // 90 deg, Q16
    localparam int LON_SHIFT = 4915200;   // 75 deg, Q16

    localparam logic signed [CW-1:0] Q30_ONE     = 34'sd1073741824;
    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [34:0]   D2R_Q38     = 35'sd4797524517;
    localparam logic [27:0]          RADIUS_Q16  = 28'd163600164;

    localparam int COL_OFFSET = 102656;   // 401 * 256
    localparam int ROW_OFFSET = 409856;   // 1601 * 256
    localparam int OUT_MAX    = 8388607;
    localparam int OUT_MIN    = -8388608;

    // Special-angle flags carried alongside the CORDIC
    typedef struct packed {
        logic neg_cos;
        logic zero;
        logic qpos;
        logic qneg;
    } hrap_trig_flags_t;

    // Per-coordinate sideband carried through the divider
    typedef struct packed {
        logic pole;   // 1 + sin(lat) <= 0
        logic tpos;   // trig factor > 0
        logic tneg;   // trig factor < 0
        logic pneg;   // product negative
    } hrap_side_t;

    // atan(2^-i) in Q30, rounded
    function automatic logic signed [CW-1:0] atan_q30(input logic [4:0] idx);
        logic signed [CW-1:0] a;
        unique case (idx)
            5'd0:  a = 34'sd843314857;
            5'd1:  a = 34'sd497837829;
            5'd2:  a = 34'sd263043837;
            5'd3:  a = 34'sd133525159;
            5'd4:  a = 34'sd67021687;
            5'd5:  a = 34'sd33543516;
            5'd6:  a = 34'sd16775851;
            5'd7:  a = 34'sd8388437;
            5'd8:  a = 34'sd4194283;
            5'd9:  a = 34'sd2097149;
            5'd10: a = 34'sd1048576;
            5'd11: a = 34'sd524288;
            5'd12: a = 34'sd262144;
            5'd13: a = 34'sd131072;
            5'd14: a = 34'sd65536;
            5'd15: a = 34'sd32768;
            5'd16: a = 34'sd16384;
            5'd17: a = 34'sd8192;
            5'd18: a = 34'sd4096;
            5'd19: a = 34'sd2048;
            5'd20: a = 34'sd1024;
            5'd21: a = 34'sd512;
            5'd22: a = 34'sd256;
            5'd23: a = 34'sd128;
            5'd24: a = 34'sd64;
            5'd25: a = 34'sd32;
            5'd26: a = 34'sd16;
            5'd27: a = 34'sd8;
            5'd28: a = 34'sd4;
            5'd29: a = 34'sd2;
            5'd30: a = 34'sd1;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

// ===== rtl/core/hrap_cordic.sv =====
// ============================================================================
// hrap_cordic
// Pipelined sine/cosine of an angle in Q16 degrees: range reduction, fold,
// degree-to-radian scaling, then one CORDIC rotation per stage.
// ============================================================================
module hrap_cordic #(
    parameter int ITER = 20
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                in_valid,
    input  logic signed [hrap_pkg::DEG_W-1:0]   angle,
    output logic                                out_valid,
    output logic signed [hrap_pkg::TRIG_W-1:0]  sin_out,
    output logic signed [hrap_pkg::TRIG_W-1:0]  cos_out
);
    import hrap_pkg::*;

    localparam int EXT_W = DEG_W + 2;
    localparam int D1_W  = 25;
    localparam int D2_W  = 24;
    localparam int MUL_W = 58;

    // stage 1: reduce into (-180, 180]
    logic signed [EXT_W-1:0] ext;
    logic signed [EXT_W-1:0] red;
    logic signed [D1_W-1:0]  d1_reg;
    logic                    v1_reg;

    always_comb
    begin
        ext = EXT_W'(angle);
        red = ext;
        for (int k = -3; k <= 3; k++)
        begin
            if (ext > (2 * k - 1) * HALF_TURN && ext <= (2 * k + 1) * HALF_TURN)
            begin
                red = EXT_W'(ext - k * FULL_TURN);
            end
        end
    end

    // stage 2: fold into [-90, 90]
    logic signed [D2_W-1:0]  d2_next;
    logic                    neg_next;
    logic signed [D2_W-1:0]  d2_reg;
    hrap_trig_flags_t        f2_reg;
    logic                    v2_reg;

    always_comb
    begin
        neg_next = 1'b1;
        if (d1_reg > QUARTER)
        begin
            d2_next = D2_W'(HALF_TURN - d1_reg);
        end
        else if (d1_reg < -QUARTER)
        begin
            d2_next = D2_W'(-HALF_TURN - d1_reg);
        end
        else
        begin
            d2_next  = D2_W'(d1_reg);
            neg_next = 1'b0;
        end
    end

    // stage 3: degrees to radians product
    logic signed [MUL_W-1:0] mul_next;
    logic signed [MUL_W-1:0] mul_reg;
    hrap_trig_flags_t        f3_reg;
    logic                    v3_reg;

    assign mul_next = d2_reg * D2R_Q38;

    // stage 4: round into Q30 radians, seed the CORDIC
    logic [MUL_W-1:0]        mul_mag;
    logic [MUL_W-1:0]        mul_rnd;
    logic signed [CW-1:0]    z_seed;

    always_comb
    begin
        mul_mag = mul_reg[MUL_W-1] ? MUL_W'(-mul_reg) : MUL_W'(mul_reg);
        mul_rnd = (mul_mag + (MUL_W'(1) << 23)) >> 24;
        z_seed  = mul_reg[MUL_W-1] ? -CW'(mul_rnd) : CW'(mul_rnd);
    end

    logic signed [CW-1:0] x_reg [0:ITER];
    logic signed [CW-1:0] y_reg [0:ITER];
    logic signed [CW-1:0] z_reg [0:ITER];
    hrap_trig_flags_t     f_reg [0:ITER];
    logic                 v_reg [0:ITER];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            v1_reg   <= in_valid;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            v_reg[0] <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d1_reg         <= D1_W'(red);
            d2_reg         <= d2_next;
            f2_reg.neg_cos <= neg_next;
            f2_reg.zero    <= (d2_next == '0);
            f2_reg.qpos    <= (d2_next == D2_W'(QUARTER));
            f2_reg.qneg    <= (d2_next == D2_W'(-QUARTER));
            mul_reg        <= mul_next;
            f3_reg         <= f2_reg;
            x_reg[0]       <= CORDIC_GAIN;
            y_reg[0]       <= '0;
            z_reg[0]       <= z_seed;
            f_reg[0]       <= f3_reg;
        end
    end

    // one rotation per stage
    for (genvar i = 0; i < ITER; i++)
    begin : g_rot
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;

        assign dx = y_reg[i] >>> i;
        assign dy = x_reg[i] >>> i;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i+1] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[i+1] <= v_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!z_reg[i][CW-1])
                begin
                    x_reg[i+1] <= x_reg[i] - dx;
                    y_reg[i+1] <= y_reg[i] + dy;
                    z_reg[i+1] <= z_reg[i] - atan_q30(5'(i));
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + dx;
                    y_reg[i+1] <= y_reg[i] - dy;
                    z_reg[i+1] <= z_reg[i] + atan_q30(5'(i));
                end
                f_reg[i+1] <= f_reg[i];
            end
        end
    end

    // output: exact values at 0 and +-90 degrees, cosine sign from fold
    logic signed [CW-1:0] s_fin;
    logic signed [CW-1:0] c_fin;
    logic                 vo_reg;
    logic signed [TRIG_W-1:0] sin_reg;
    logic signed [TRIG_W-1:0] cos_reg;

    always_comb
    begin
        if (f_reg[ITER].zero)
        begin
            s_fin = '0;
            c_fin = f_reg[ITER].neg_cos ? -Q30_ONE : Q30_ONE;
        end
        else if (f_reg[ITER].qpos)
        begin
            s_fin = Q30_ONE;
            c_fin = '0;
        end
        else if (f_reg[ITER].qneg)
        begin
            s_fin = -Q30_ONE;
            c_fin = '0;
        end
        else
        begin
            s_fin = y_reg[ITER];
            c_fin = f_reg[ITER].neg_cos ? -x_reg[ITER] : x_reg[ITER];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vo_reg <= 1'b0;
        end
        else if (en)
        begin
            vo_reg <= v_reg[ITER];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sin_reg <= TRIG_W'(s_fin);
            cos_reg <= TRIG_W'(c_fin);
        end
    end

    assign out_valid = vo_reg;
    assign sin_out   = sin_reg;
    assign cos_out   = cos_reg;

endmodule

// ===== rtl/core/hrap_div.sv =====
// ============================================================================
// hrap_div
// Pipelined rounded divide: round(num / (den * 256)), one quotient bit per
// stage, with an overflow flag when the quotient does not fit.
// ============================================================================
module hrap_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic [hrap_pkg::MAG_W-1:0]        num,
    input  logic [hrap_pkg::DEN_W-1:0]        den,
    input  hrap_pkg::hrap_side_t              side,
    output logic                              out_valid,
    output logic [hrap_pkg::DIV_QW-1:0]       quo,
    output logic                              ovf,
    output hrap_pkg::hrap_side_t              side_out
);
    import hrap_pkg::*;

    // round then pre-scale: floor((num + 128*den) / 256) / den
    logic [MAG_W:0]    sum;
    logic [DIV_NW-1:0] nq;
    logic              ovf_next;

    always_comb
    begin
        sum      = (MAG_W+1)'(num) + (MAG_W+1)'({den, 7'b0});
        nq       = sum[MAG_W:8];
        ovf_next = DIV_RW'(nq) >= (DIV_RW'(den) << DIV_QW);
    end

    logic [DIV_RW-1:0] rem_reg [0:DIV_QW];
    logic [DIV_QW-1:0] q_reg   [0:DIV_QW];
    logic [DEN_W-1:0]  den_reg [0:DIV_QW];
    logic              ovf_reg [0:DIV_QW];
    hrap_side_t        side_reg[0:DIV_QW];
    logic              v_reg   [0:DIV_QW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= ovf_next ? '0 : DIV_RW'(nq);
            q_reg[0]    <= '0;
            den_reg[0]  <= den;
            ovf_reg[0]  <= ovf_next;
            side_reg[0] <= side;
        end
    end

    for (genvar k = 0; k < DIV_QW; k++)
    begin : g_bit
        localparam int B = DIV_QW - 1 - k;
        logic [DIV_RW-1:0] dsh;

        assign dsh = DIV_RW'(den_reg[k]) << B;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k+1] <= v_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (rem_reg[k] >= dsh)
                begin
                    rem_reg[k+1] <= rem_reg[k] - dsh;
                    q_reg[k+1]   <= q_reg[k] | (DIV_QW'(1) << B);
                end
                else
                begin
                    rem_reg[k+1] <= rem_reg[k];
                    q_reg[k+1]   <= q_reg[k];
                end
                den_reg[k+1]  <= den_reg[k];
                ovf_reg[k+1]  <= ovf_reg[k];
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    assign out_valid = v_reg[DIV_QW];
    assign quo       = q_reg[DIV_QW];
    assign ovf       = ovf_reg[DIV_QW];
    assign side_out  = side_reg[DIV_QW];

endmodule

// ===== rtl/core/latlon_to_hrap_grid.sv =====
// ============================================================================
// latlon_to_hrap_grid
// Latitude/longitude to HRAP polar stereographic grid column and row.
// ============================================================================
// Usage:
//   Input stream (s_*): one transaction per point, tdata = latitude[23:0]
//   and longitude[49:24], both Q16 degrees, signed.
//   Output stream (m_*): one transaction per point, in order, tdata =
//   grid_x[23:0] and grid_y[47:24] (Q8, signed), tuser = saturated.
//   saturated is set when a coordinate was clipped to the 24-bit range or
//   the latitude sits at the south-pole singularity.
// Throughput: one point per cycle while results are accepted.
// Depth: set by the CORDIC stages (one rotation each) and the
//   25-stage quotient divider.
// Stall: the whole pipeline advances on one enable; while a result sits
//   in the output register unaccepted, s_tready drops and every stage
//   holds, so nothing is lost or repeated.
// Reset: clears all stage valid bits; the pipeline comes up empty.
// ============================================================================
module latlon_to_hrap_grid #(
    parameter int TRIG_ITERATIONS = 20
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // latitude[23:0], longitude[49:24], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // grid_x[23:0], grid_y[47:24]
    output logic        m_tuser    // saturated[0]
);
    import hrap_pkg::*;

    // global advance: output register empty or being taken
    logic en;
    logic m_tvalid_reg;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    // Input angles: latitude as is, longitude shifted by 75 degrees
    logic signed [23:0]      lat_in;
    logic signed [25:0]      lon_in;
    logic signed [DEG_W-1:0] lat_deg;
    logic signed [DEG_W-1:0] ang_deg;

    assign lat_in  = s_tdata[23:0];
    assign lon_in  = s_tdata[49:24];
    assign lat_deg = DEG_W'(lat_in);
    assign ang_deg = DEG_W'(lon_in) + DEG_W'(LON_SHIFT);

    logic                      trig_valid;
    logic signed [TRIG_W-1:0]  s_lat;
    logic signed [TRIG_W-1:0]  c_lat;
    logic signed [TRIG_W-1:0]  s_ang;
    logic signed [TRIG_W-1:0]  c_ang;

    hrap_cordic #(
        .ITER (TRIG_ITERATIONS)
    ) u_cordic_lat (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .angle     (lat_deg),
        .out_valid (trig_valid),
        .sin_out   (s_lat),
        .cos_out   (c_lat)
    );

    hrap_cordic #(
        .ITER (TRIG_ITERATIONS)
    ) u_cordic_ang (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .angle     (ang_deg),
        .out_valid (),
        .sin_out   (s_ang),
        .cos_out   (c_ang)
    );

    // T1: cos(lat) * trig products, denominator 1 + sin(lat)
    logic signed [63:0]   prod_x_reg;
    logic signed [63:0]   prod_y_reg;
    logic signed [CW-1:0] den_reg;
    logic                 tpos_x_reg;
    logic                 tneg_x_reg;
    logic                 tpos_y_reg;
    logic                 tneg_y_reg;
    logic                 t1_valid_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_x_reg <= c_lat * s_ang;
            prod_y_reg <= c_lat * c_ang;
            den_reg    <= Q30_ONE + CW'(s_lat);
            tpos_x_reg <= (s_ang > 0);
            tneg_x_reg <= (s_ang < 0);
            tpos_y_reg <= (c_ang > 0);
            tneg_y_reg <= (c_ang < 0);
        end
    end

    // T2: round products back to Q30, keep sign and magnitude apart
    logic [63:0]      mag_x;
    logic [63:0]      mag_y;
    logic             pole;
    logic [31:0]      pmag_x_reg;
    logic [31:0]      pmag_y_reg;
    hrap_side_t       side_x_t2_reg;
    hrap_side_t       side_y_t2_reg;
    logic [DEN_W-1:0] den_t2_reg;
    logic             t2_valid_reg;

    always_comb
    begin
        mag_x = prod_x_reg[63] ? 64'(-prod_x_reg) : 64'(prod_x_reg);
        mag_y = prod_y_reg[63] ? 64'(-prod_y_reg) : 64'(prod_y_reg);
        mag_x = mag_x + (64'(1) << 29);
        mag_y = mag_y + (64'(1) << 29);
        pole  = (den_reg <= 0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pmag_x_reg    <= mag_x[61:30];
            pmag_y_reg    <= mag_y[61:30];
            side_x_t2_reg <= '{pole: pole, tpos: tpos_x_reg, tneg: tneg_x_reg,
                               pneg: prod_x_reg[63]};
            side_y_t2_reg <= '{pole: pole, tpos: tpos_y_reg, tneg: tneg_y_reg,
                               pneg: prod_y_reg[63]};
            // a pole point divides by one; its quotient is ignored
            den_t2_reg    <= pole ? DEN_W'(1) : DEN_W'(den_reg);
        end
    end

    // T3: scale by the radius constant
    logic [MAG_W-1:0] num_x_reg;
    logic [MAG_W-1:0] num_y_reg;
    hrap_side_t       side_x_t3_reg;
    hrap_side_t       side_y_t3_reg;
    logic [DEN_W-1:0] den_t3_reg;
    logic             t3_valid_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_x_reg     <= MAG_W'(RADIUS_Q16 * pmag_x_reg);
            num_y_reg     <= MAG_W'(RADIUS_Q16 * pmag_y_reg);
            side_x_t3_reg <= side_x_t2_reg;
            side_y_t3_reg <= side_y_t2_reg;
            den_t3_reg    <= den_t2_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t1_valid_reg <= 1'b0;
            t2_valid_reg <= 1'b0;
            t3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            t1_valid_reg <= trig_valid;
            t2_valid_reg <= t1_valid_reg;
            t3_valid_reg <= t2_valid_reg;
        end
    end

    // Divide by (1 + sin(lat)) * 256, both coordinates side by side
    logic              div_valid;
    logic [DIV_QW-1:0] quo_x;
    logic [DIV_QW-1:0] quo_y;
    logic              ovf_x;
    logic              ovf_y;
    hrap_side_t        side_x;
    hrap_side_t        side_y;

    hrap_div u_div_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (t3_valid_reg),
        .num       (num_x_reg),
        .den       (den_t3_reg),
        .side      (side_x_t3_reg),
        .out_valid (div_valid),
        .quo       (quo_x),
        .ovf       (ovf_x),
        .side_out  (side_x)
    );

    hrap_div u_div_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (t3_valid_reg),
        .num       (num_y_reg),
        .den       (den_t3_reg),
        .side      (side_y_t3_reg),
        .out_valid (),
        .quo       (quo_y),
        .ovf       (ovf_y),
        .side_out  (side_y)
    );

    // Offset, pole handling and clip; returns {flag, value}
    function automatic logic [24:0] place(input logic [DIV_QW-1:0] q,
                                          input logic ovf,
                                          input hrap_side_t sd,
                                          input int offset);
        logic signed [26:0] sq;
        logic signed [26:0] v;
        logic signed [23:0] val;
        logic               flag;
        sq   = sd.pneg ? -27'({2'b0, q}) : 27'({2'b0, q});
        v    = sq + 27'(offset);
        flag = 1'b1;
        if (sd.pole)
        begin
            // infinite radius: the trig sign picks the end
            if (sd.tpos)
                val = 24'(OUT_MAX);
            else if (sd.tneg)
                val = 24'(OUT_MIN);
            else
                val = 24'(offset);
        end
        else if (ovf)
        begin
            val = sd.pneg ? 24'(OUT_MIN) : 24'(OUT_MAX);
        end
        else if (v > OUT_MAX)
        begin
            val = 24'(OUT_MAX);
        end
        else if (v < OUT_MIN)
        begin
            val = 24'(OUT_MIN);
        end
        else
        begin
            val  = 24'(v);
            flag = 1'b0;
        end
        return {flag, val};
    endfunction

    logic [24:0] res_x;
    logic [24:0] res_y;

    assign res_x = place(quo_x, ovf_x, side_x, COL_OFFSET);
    assign res_y = place(quo_y, ovf_y, side_y, ROW_OFFSET);

    // Output register
    logic [47:0] m_tdata_reg;
    logic        m_tuser_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (en)
        begin
            m_tvalid_reg <= div_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_tdata_reg <= {res_y[23:0], res_x[23:0]};
            m_tuser_reg <= res_x[24] | res_y[24];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ===== rtl/core/hrap_checker.sv =====
// ============================================================================
// hrap_checker
// Port-level checks on the HRAP projection streams, bound to the top level.
// ============================================================================
module hrap_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [55:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic        m_tuser
);

    // stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("result dropped while stalled");

    // stalled result does not change
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> ($stable(m_tdata) && $stable(m_tuser)))
        else $error("result changed while stalled");

    // waiting input transaction stays offered and unchanged
    a_in_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && !s_tready) |=> (s_tvalid && $stable(s_tdata)))
        else $error("input changed while stalled");

    // input side moves exactly when the output register can move
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("s_tready does not follow output stall");

    // pipeline comes out of reset empty
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !m_tvalid)
        else $error("result present at reset release");

endmodule

bind latlon_to_hrap_grid hrap_checker u_hrap_checker (.*);
